### rtl/ffha_pkg.sv
package ffha_pkg;

  // fixed field widths and arena constants
  localparam int AW = 21;
  localparam int GW = 17;
  localparam int DW = 22;
  localparam int SW = 40;
  localparam int HEADER_BYTES = 40;
  localparam int HEAP_BYTES = 1048576;
  localparam logic [AW-1:0] HDR_BYTES = AW'(HEADER_BYTES);
  localparam logic [GW-1:0] GRAN_RESET = GW'(4096);
  localparam logic [GW-1:0] GRAN_MIN = GW'(2 * HEADER_BYTES);

  // request kinds
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_OOM = 2'd2;
  localparam logic [1:0] ST_FREED = 2'd3;

  // datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE = 5'd0;
  localparam op_t OP_LATCH = 5'd1;
  localparam op_t OP_HRESET = 5'd2;
  localparam op_t OP_ST_NULL = 5'd3;
  localparam op_t OP_RD_I = 5'd4;
  localparam op_t OP_NEXT = 5'd5;
  localparam op_t OP_REUSE = 5'd6;
  localparam op_t OP_SPLIT = 5'd7;
  localparam op_t OP_RD_KM1 = 5'd8;
  localparam op_t OP_SH_WR = 5'd9;
  localparam op_t OP_INS = 5'd10;
  localparam op_t OP_DIVI = 5'd11;
  localparam op_t OP_DIVS = 5'd12;
  localparam op_t OP_MUL = 5'd13;
  localparam op_t OP_OOM = 5'd14;
  localparam op_t OP_APPEND = 5'd15;
  localparam op_t OP_REFIND = 5'd16;
  localparam op_t OP_ASTART = 5'd17;
  localparam op_t OP_HIT = 5'd18;
  localparam op_t OP_ST_FREE = 5'd19;
  localparam op_t OP_INPLACE = 5'd20;
  localparam op_t OP_MOVE = 5'd21;
  localparam op_t OP_FREE0 = 5'd22;
  localparam op_t OP_RD_LOM1 = 5'd23;
  localparam op_t OP_BK = 5'd24;
  localparam op_t OP_RD_HIP1 = 5'd25;
  localparam op_t OP_FW = 5'd26;
  localparam op_t OP_MERGE = 5'd27;
  localparam op_t OP_RD_K = 5'd28;
  localparam op_t OP_CP_WR = 5'd29;
  localparam op_t OP_SHRINK = 5'd30;
  localparam op_t OP_OUT = 5'd31;

  // one table entry
  typedef struct packed {
    logic            is_free;
    logic [AW-1:0]   used;
    logic [AW-1:0]   cap;
    logic [AW-1:0]   hdr;
  } entry_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       addr_zero;
    logic       size_zero;
    logic       i_lt_count;
    logic       fit;
    logic       rd_free;
    logic       split_ok;
    logic       match;
    logic       ent_free;
    logic       ent_fits;
    logic       div_last;
    logic       oom;
    logic       mv;
    logic       refind;
    logic       st_ok;
    logic       k_gt_ip1;
    logic       lo_nz;
    logic       hi_lt;
    logic       k_lt_count;
    logic       out_free;
  } dp_sts_t;

endpackage

### rtl/ffha_ram.sv
module ffha_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/ffha_ctrl.sv
module ffha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ffha_pkg::dp_sts_t  sts_i,
  output ffha_pkg::ctrl_cmd_t cmd_o
);
  import ffha_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_ASTART = 5'd2;
  localparam logic [4:0] S_A_RD = 5'd3;
  localparam logic [4:0] S_A_EV = 5'd4;
  localparam logic [4:0] S_SH_CHK = 5'd5;
  localparam logic [4:0] S_SH_WR = 5'd6;
  localparam logic [4:0] S_DIV_INIT = 5'd7;
  localparam logic [4:0] S_DIV = 5'd8;
  localparam logic [4:0] S_MUL = 5'd9;
  localparam logic [4:0] S_GROW = 5'd10;
  localparam logic [4:0] S_ADONE = 5'd11;
  localparam logic [4:0] S_FIND_RD = 5'd12;
  localparam logic [4:0] S_FIND_EV = 5'd13;
  localparam logic [4:0] S_FOUND = 5'd14;
  localparam logic [4:0] S_FREE0 = 5'd15;
  localparam logic [4:0] S_BK_CHK = 5'd16;
  localparam logic [4:0] S_BK_EV = 5'd17;
  localparam logic [4:0] S_FW_CHK = 5'd18;
  localparam logic [4:0] S_FW_EV = 5'd19;
  localparam logic [4:0] S_MERGE = 5'd20;
  localparam logic [4:0] S_CP_CHK = 5'd21;
  localparam logic [4:0] S_CP_WR = 5'd22;
  localparam logic [4:0] S_FIN = 5'd23;

  logic [4:0] state_q, state_d;
  op_t        op;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.op = op;

  // next state and datapath operation
  always_comb begin
    state_d = state_q;
    op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op = OP_LATCH;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.cmd == CMD_RESET) begin
          op = OP_HRESET;
          state_d = S_FIN;
        end else if (sts_i.cmd == CMD_ALLOC) begin
          state_d = S_ASTART;
        end else if (sts_i.addr_zero) begin
          state_d = (sts_i.cmd == CMD_REALLOC) ? S_ASTART : S_FIN;
        end else begin
          state_d = S_FIND_RD;
        end
      end
      S_ASTART: begin
        if (sts_i.size_zero) begin
          op = OP_ST_NULL;
          state_d = S_FIN;
        end else begin
          op = OP_ASTART;
          state_d = S_A_RD;
        end
      end
      S_A_RD: begin
        if (sts_i.i_lt_count) begin
          op = OP_RD_I;
          state_d = S_A_EV;
        end else begin
          state_d = S_DIV_INIT;
        end
      end
      S_A_EV: begin
        if (sts_i.fit && sts_i.rd_free) begin
          op = OP_REUSE;
          state_d = S_ADONE;
        end else if (sts_i.fit && sts_i.split_ok) begin
          op = OP_SPLIT;
          state_d = S_SH_CHK;
        end else begin
          op = OP_NEXT;
          state_d = S_A_RD;
        end
      end
      S_SH_CHK: begin
        if (sts_i.k_gt_ip1) begin
          op = OP_RD_KM1;
          state_d = S_SH_WR;
        end else begin
          op = OP_INS;
          state_d = S_ADONE;
        end
      end
      S_SH_WR: begin
        op = OP_SH_WR;
        state_d = S_SH_CHK;
      end
      S_DIV_INIT: begin
        op = OP_DIVI;
        state_d = S_DIV;
      end
      S_DIV: begin
        op = OP_DIVS;
        if (sts_i.div_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        op = OP_MUL;
        state_d = S_GROW;
      end
      S_GROW: begin
        op = sts_i.oom ? OP_OOM : OP_APPEND;
        state_d = S_ADONE;
      end
      S_ADONE: begin
        if (sts_i.mv && sts_i.st_ok) begin
          op = OP_REFIND;
          state_d = S_FIND_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIND_RD: begin
        if (sts_i.i_lt_count) begin
          op = OP_RD_I;
          state_d = S_FIND_EV;
        end else begin
          op = sts_i.refind ? OP_NONE : OP_ST_NULL;
          state_d = S_FIN;
        end
      end
      S_FIND_EV: begin
        if (sts_i.match) begin
          op = OP_HIT;
          state_d = S_FOUND;
        end else begin
          op = OP_NEXT;
          state_d = S_FIND_RD;
        end
      end
      S_FOUND: begin
        if (sts_i.refind) begin
          state_d = S_FREE0;
        end else if (sts_i.ent_free) begin
          op = OP_ST_FREE;
          state_d = S_FIN;
        end else if (sts_i.cmd == CMD_FREE) begin
          state_d = S_FREE0;
        end else if (sts_i.size_zero) begin
          op = OP_ST_NULL;
          state_d = S_FREE0;
        end else if (sts_i.ent_fits) begin
          op = OP_INPLACE;
          state_d = S_FIN;
        end else begin
          op = OP_MOVE;
          state_d = S_ASTART;
        end
      end
      S_FREE0: begin
        op = OP_FREE0;
        state_d = S_BK_CHK;
      end
      S_BK_CHK: begin
        if (sts_i.lo_nz) begin
          op = OP_RD_LOM1;
          state_d = S_BK_EV;
        end else begin
          state_d = S_FW_CHK;
        end
      end
      S_BK_EV: begin
        if (sts_i.rd_free) begin
          op = OP_BK;
          state_d = S_BK_CHK;
        end else begin
          state_d = S_FW_CHK;
        end
      end
      S_FW_CHK: begin
        if (sts_i.hi_lt) begin
          op = OP_RD_HIP1;
          state_d = S_FW_EV;
        end else begin
          state_d = S_MERGE;
        end
      end
      S_FW_EV: begin
        if (sts_i.rd_free) begin
          op = OP_FW;
          state_d = S_FW_CHK;
        end else begin
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        op = OP_MERGE;
        state_d = S_CP_CHK;
      end
      S_CP_CHK: begin
        if (sts_i.k_lt_count) begin
          op = OP_RD_K;
          state_d = S_CP_WR;
        end else begin
          op = OP_SHRINK;
          state_d = S_FIN;
        end
      end
      S_CP_WR: begin
        op = OP_CP_WR;
        state_d = S_CP_CHK;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          op = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/ffha_dp.sv
module ffha_dp #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffha_pkg::ctrl_cmd_t cmd_i,
  output ffha_pkg::dp_sts_t   sts_o,
  input  logic [47:0]         in_data_i,
  input  logic                cfg_valid_i,
  input  logic [16:0]         cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [47:0]         out_data_o
);
  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] One = CW'(1);

  // control state
  logic [GW-1:0] gran_q;
  logic [CW-1:0] count_q;
  logic [AW-1:0] top_q;
  logic          out_valid_q;

  // request and work registers
  logic [1:0]    cmd_q;
  logic [AW-1:0] size_q, addr_q;
  logic [CW-1:0] i_q, k_q, lo_q, hi_q;
  entry_t        ent_q, nb_q;
  logic [AW-1:0] acc_q, hdrlo_q, oldcap_q;
  logic [DW-1:0] n_q, quot_q;
  logic [GW-1:0] rem_q;
  logic [4:0]    dcnt_q;
  logic [SW-1:0] span_q;
  logic [AW-1:0] res_q, copy_q;
  logic [1:0]    st_q;
  logic          moved_q, mv_q, refind_q;
  logic [47:0]   out_q;

  // table memory
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd;
  logic [63:0]   ram_rdata;

  ffha_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  // derived values
  logic [AW:0]   room;
  logic [CW-1:0] gap;
  logic [GW:0]   r2;
  logic          ge;
  logic [DW:0]   qp1;
  logic [GW-1:0] cfg_val;

  assign room = {1'b0, rd.cap} - {1'b0, rd.used};
  assign gap = hi_q - lo_q;
  assign r2 = {rem_q, n_q[DW-1]};
  assign ge = r2 >= {1'b0, gran_q};
  assign qp1 = {1'b0, quot_q} + (DW+1)'(1);
  assign cfg_val = (cfg_data_i < GRAN_MIN) ? GRAN_MIN : cfg_data_i;

  // status to the controller
  assign sts_o.cmd = cmd_q;
  assign sts_o.addr_zero = (addr_q == '0);
  assign sts_o.size_zero = (size_q == '0);
  assign sts_o.i_lt_count = (i_q < count_q);
  assign sts_o.fit = (room >= {1'b0, size_q});
  assign sts_o.rd_free = rd.is_free;
  assign sts_o.split_ok = ({1'b0, room} >= ({2'b0, size_q} + {2'b0, HDR_BYTES}))
                          && (count_q < MaxCnt);
  assign sts_o.match = (({1'b0, rd.hdr} + {1'b0, HDR_BYTES}) == {1'b0, addr_q});
  assign sts_o.ent_free = ent_q.is_free;
  assign sts_o.ent_fits = (ent_q.cap >= size_q);
  assign sts_o.div_last = (dcnt_q == 5'd1);
  assign sts_o.oom = (count_q >= MaxCnt)
                     || (span_q > (SW'(HEAP_BYTES) - SW'(top_q)));
  assign sts_o.mv = mv_q;
  assign sts_o.refind = refind_q;
  assign sts_o.st_ok = (st_q == ST_OK);
  assign sts_o.k_gt_ip1 = (k_q > (i_q + One));
  assign sts_o.lo_nz = (lo_q != '0);
  assign sts_o.hi_lt = ((hi_q + One) < count_q);
  assign sts_o.k_lt_count = (k_q < count_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // memory port selection
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = i_q[IW-1:0];
    ram_wdata = rd;
    ram_raddr = i_q[IW-1:0];
    case (cmd_i.op)
      OP_RD_KM1:  ram_raddr = IW'(k_q - One);
      OP_RD_LOM1: ram_raddr = IW'(lo_q - One);
      OP_RD_HIP1: ram_raddr = IW'(hi_q + One);
      OP_RD_K:    ram_raddr = k_q[IW-1:0];
      OP_REUSE: begin
        ram_we = 1'b1;
        ram_wdata = '{is_free: 1'b0, used: size_q, cap: rd.cap, hdr: rd.hdr};
      end
      OP_SPLIT: begin
        ram_we = 1'b1;
        ram_wdata = '{is_free: 1'b0, used: rd.used, cap: rd.used, hdr: rd.hdr};
      end
      OP_SH_WR: begin
        ram_we = 1'b1;
        ram_waddr = k_q[IW-1:0];
      end
      OP_INS: begin
        ram_we = 1'b1;
        ram_waddr = IW'(i_q + One);
        ram_wdata = nb_q;
      end
      OP_APPEND: begin
        ram_we = 1'b1;
        ram_waddr = count_q[IW-1:0];
        ram_wdata = '{is_free: 1'b0, used: size_q,
                      cap: AW'(span_q) - HDR_BYTES, hdr: top_q};
      end
      OP_INPLACE: begin
        ram_we = 1'b1;
        ram_wdata = '{is_free: 1'b0, used: size_q, cap: ent_q.cap, hdr: ent_q.hdr};
      end
      OP_MERGE: begin
        ram_we = 1'b1;
        ram_waddr = lo_q[IW-1:0];
        ram_wdata = '{is_free: 1'b1, used: '0, cap: acc_q, hdr: hdrlo_q};
      end
      OP_CP_WR: begin
        ram_we = 1'b1;
        ram_waddr = IW'(k_q - gap);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // heap bookkeeping, granule and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gran_q <= GRAN_RESET;
      count_q <= '0;
      top_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_data_i != '0)) begin
        gran_q <= cfg_val;
      end
      case (cmd_i.op)
        OP_HRESET: begin
          count_q <= '0;
          top_q <= '0;
        end
        OP_INS:    count_q <= count_q + One;
        OP_APPEND: begin
          count_q <= count_q + One;
          top_q <= top_q + AW'(span_q);
        end
        OP_SHRINK: count_q <= count_q - gap;
        default: begin
          count_q <= count_q;
        end
      endcase
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        cmd_q <= in_data_i[1:0];
        size_q <= in_data_i[22:2];
        addr_q <= in_data_i[43:23];
        res_q <= '0;
        st_q <= ST_OK;
        moved_q <= 1'b0;
        copy_q <= '0;
        mv_q <= 1'b0;
        refind_q <= 1'b0;
        i_q <= '0;
      end
      OP_ST_NULL: st_q <= ST_NULL;
      OP_ST_FREE: st_q <= ST_FREED;
      OP_NEXT:    i_q <= i_q + One;
      OP_ASTART:  i_q <= '0;
      OP_REUSE: begin
        res_q <= rd.hdr + HDR_BYTES;
        st_q <= ST_OK;
      end
      OP_SPLIT: begin
        nb_q <= '{is_free: 1'b0, used: size_q,
                  cap: rd.cap - HDR_BYTES - rd.used,
                  hdr: rd.hdr + HDR_BYTES + rd.used};
        res_q <= rd.hdr + HDR_BYTES + rd.used + HDR_BYTES;
        st_q <= ST_OK;
        k_q <= count_q;
      end
      OP_SH_WR: k_q <= k_q - One;
      OP_DIVI: begin
        n_q <= {1'b0, size_q} + {1'b0, HDR_BYTES};
        rem_q <= '0;
        quot_q <= '0;
        dcnt_q <= 5'(DW);
      end
      OP_DIVS: begin
        rem_q <= ge ? GW'(r2 - {1'b0, gran_q}) : r2[GW-1:0];
        quot_q <= {quot_q[DW-2:0], ge};
        n_q <= {n_q[DW-2:0], 1'b0};
        dcnt_q <= dcnt_q - 5'd1;
      end
      OP_MUL: span_q <= SW'(qp1) * SW'(gran_q);
      OP_OOM: begin
        res_q <= '0;
        st_q <= ST_OOM;
      end
      OP_APPEND: begin
        res_q <= top_q + HDR_BYTES;
        st_q <= ST_OK;
      end
      OP_REFIND: begin
        moved_q <= 1'b1;
        copy_q <= oldcap_q;
        i_q <= '0;
        refind_q <= 1'b1;
      end
      OP_HIT:     ent_q <= rd;
      OP_INPLACE: res_q <= addr_q;
      OP_MOVE: begin
        oldcap_q <= ent_q.cap;
        mv_q <= 1'b1;
      end
      OP_FREE0: begin
        acc_q <= ent_q.cap;
        hdrlo_q <= ent_q.hdr;
        lo_q <= i_q;
        hi_q <= i_q;
      end
      OP_BK: begin
        lo_q <= lo_q - One;
        acc_q <= acc_q + rd.cap + HDR_BYTES;
        hdrlo_q <= rd.hdr;
      end
      OP_FW: begin
        hi_q <= hi_q + One;
        acc_q <= acc_q + rd.cap + HDR_BYTES;
      end
      OP_MERGE:  k_q <= hi_q + One;
      OP_CP_WR:  k_q <= k_q + One;
      OP_OUT:    out_q <= {3'b0, copy_q, moved_q, st_q, res_q};
      default: begin
        i_q <= i_q;
      end
    endcase
  end

endmodule

### rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: keeps an address-ordered table of up to MAX_BLOCKS
// blocks in one on-chip memory and serves alloc, free, realloc and heap reset
// requests one at a time. Every walk over the table goes through the single
// registered read port of the table memory: the first-fit search, the shift
// that opens a slot for a split, the address lookup (done twice when realloc
// moves), and the backward, forward and compaction passes of a free. Growing
// the heap adds a serial granule division and a multiply. A finished result
// sits in an output register, so a new request is taken while it waits.
// grow_granule may only be written while no request is in flight.
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // cmd, request_size, block_address
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // result_address, status, moved, copy_bytes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i     // grow_granule
);
  import ffha_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  assign cfg_ready_o = 1'b1;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  ffha_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  // a taken request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one still in work");

  // a moved block is only reported with ok status
  a_moved_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[22:21] == ST_OK)
    else $error("moved flag without ok status");

  // no copy length without a move
  a_copy_needs_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[23] |-> m_axis_tdata[44:24] == '0)
    else $error("copy length set on a result that did not move");

  // a result only appears after the controller finished a request
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while idle");

endmodule
